// ----- hw/rtl/bgs_pkg.sv -----
package bgs_pkg;

   localparam int MAX_HEIGHT_DEF = 64;
   localparam int MAX_WIDTH_DEF  = 64;

   localparam int FRAC_BITS  = 15;
   localparam int GRID_W     = 16;
   localparam int PIX_W      = 16;
   localparam int COORD_W    = 6;
   localparam int SIZE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_PADDING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_CORNERS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH    = 2'd3;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

endpackage

// ----- hw/rtl/bilinear_grid_sampler.sv -----
// Channel   Direction  Payload
// req_*     in         tuser: mode; tdata: pixel_row, pixel_col, pixel_value, grid_x, grid_y
// rsp_*     out        tdata: sample_value
// csr_*     in         write enable, register index, write data
//
// A load request writes the plane memory at its accept edge. A sample request passes
// through the accept, a scaling step, four single-port memory reads (one neighbour each),
// the emptying of the multiply-accumulate pipeline and a rounding step.
// A result waits in the output register while the next request is accepted; a stalled
// result holds the sequencer in its rounding step until the register frees.
// Reset clears the control state and the configuration; the plane memory is not cleared.
module bilinear_grid_sampler #(
   parameter int MAX_HEIGHT = bgs_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_WIDTH  = bgs_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_row, pixel_col, pixel_value, grid_x, grid_y, zero fill
   input  logic [bgs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // sample_value
   output logic [bgs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [bgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int MAXH_EFF = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
   localparam int MAXW_EFF = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   logic              border_ff, border_in;
   logic              align_ff, align_in;
   logic [6:0]        height_ff, height_in;
   logic [6:0]        width_ff, width_in;
   logic [2:0]        state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic signed [15:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [10:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [14:0]       fx_ff, fx_in, fy_ff, fy_in;
   logic              v1_ff, v2_ff;
   logic              zero_ff;
   logic [30:0]       wgt_ff;
   logic signed [15:0] rdata_ff;
   logic signed [47:0] prod_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic signed [15:0] plane_mem [DEPTH];

   logic [5:0]        pixel_row, pixel_col;
   logic signed [15:0] pixel_value, grid_x, grid_y;
   logic              accept, mem_we, mem_re;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [6:0]        eff_h, eff_w;
   logic [6:0]        mul_x, mul_y;
   logic signed [16:0] gpx, gpy;
   logic signed [24:0] px, py;
   logic signed [25:0] pos_x, pos_y;
   logic signed [11:0] col, row;
   logic [6:0]        col_c, row_c;
   logic              in_x, in_y;
   logic [15:0]       wx, wy;
   logic [31:0]       wprod;
   logic signed [15:0] pix;
   logic signed [47:0] rsum;
   logic signed [17:0] q;
   logic              out_free;

   assign pixel_row   = req_tdata[5:0];
   assign pixel_col   = req_tdata[11:6];
   assign pixel_value = req_tdata[27:12];
   assign grid_x      = req_tdata[43:28];
   assign grid_y      = req_tdata[59:44];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign mem_we     = accept && (req_tuser == bgs_pkg::MODE_LOAD)
                       && (int'(pixel_row) < MAX_HEIGHT) && (int'(pixel_col) < MAX_WIDTH);
   assign mem_re     = (state_ff == ST_FETCH);
   assign wr_addr    = AW'(int'(pixel_row) * MAX_WIDTH + int'(pixel_col));

   assign eff_h = (height_ff == 7'd0) ? 7'd1 :
                  (height_ff > 7'(MAXH_EFF)) ? 7'(MAXH_EFF) : height_ff;
   assign eff_w = (width_ff == 7'd0) ? 7'd1 :
                  (width_ff > 7'(MAXW_EFF)) ? 7'(MAXW_EFF) : width_ff;

   // Position in units of 2^-15 pixel.
   assign mul_x = align_ff ? (eff_w - 7'd1) : eff_w;
   assign mul_y = align_ff ? (eff_h - 7'd1) : eff_h;
   assign gpx   = {gx_ff[15], gx_ff} + 17'sd16384;
   assign gpy   = {gy_ff[15], gy_ff} + 17'sd16384;
   assign px    = gpx * $signed({1'b0, mul_x});
   assign py    = gpy * $signed({1'b0, mul_y});
   assign pos_x = {px[24], px} - (align_ff ? 26'sd0 : 26'sd16384);
   assign pos_y = {py[24], py} - (align_ff ? 26'sd0 : 26'sd16384);

   // Neighbour of the current step: bit 0 steps right, bit 1 steps down.
   assign col  = {x0_ff[10], x0_ff} + 12'(step_ff[0]);
   assign row  = {y0_ff[10], y0_ff} + 12'(step_ff[1]);
   assign in_x = !col[11] && (col[10:0] < {4'b0, eff_w});
   assign in_y = !row[11] && (row[10:0] < {4'b0, eff_h});
   assign col_c = col[11] ? 7'd0 :
                  (col[10:0] > {4'b0, eff_w - 7'd1}) ? (eff_w - 7'd1) : col[6:0];
   assign row_c = row[11] ? 7'd0 :
                  (row[10:0] > {4'b0, eff_h - 7'd1}) ? (eff_h - 7'd1) : row[6:0];
   assign rd_addr = AW'(int'(row_c) * MAX_WIDTH + int'(col_c));

   assign wx    = step_ff[0] ? {1'b0, fx_ff} : (16'd32768 - {1'b0, fx_ff});
   assign wy    = step_ff[1] ? {1'b0, fy_ff} : (16'd32768 - {1'b0, fy_ff});
   assign wprod = wx * wy;

   assign pix  = zero_ff ? 16'sd0 : rdata_ff;
   assign rsum = acc_ff + 48'sd536870912;
   assign q    = rsum[47:30];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      border_in    = border_ff;
      align_in     = align_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      acc_in       = v2_ff ? (acc_ff + prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bgs_pkg::CSR_BORDER_PADDING: border_in = csr_wdata[0];
            bgs_pkg::CSR_ALIGN_CORNERS:  align_in  = csr_wdata[0];
            bgs_pkg::CSR_PLANE_HEIGHT:   height_in = csr_wdata;
            bgs_pkg::CSR_PLANE_WIDTH:    width_in  = csr_wdata;
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == bgs_pkg::MODE_SAMPLE)) begin
               gx_in    = grid_x;
               gy_in    = grid_y;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            x0_in    = pos_x[25:15];
            y0_in    = pos_y[25:15];
            fx_in    = pos_x[14:0];
            fy_in    = pos_y[14:0];
            acc_in   = 48'sd0;
            step_in  = 2'd0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd1) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (q > 18'sd32767) begin
                  rsp_data_in = 16'h7FFF;
               end else if (q < -18'sd32768) begin
                  rsp_data_in = 16'h8000;
               end else begin
                  rsp_data_in = q[15:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff    <= 1'b0;
         align_ff     <= 1'b0;
         height_ff    <= bgs_pkg::SIZE_RESET;
         width_ff     <= bgs_pkg::SIZE_RESET;
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         border_ff    <= border_in;
         align_ff     <= align_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         v1_ff        <= mem_re;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (mem_re) begin
         zero_ff <= !border_ff && !(in_x && in_y);
         wgt_ff  <= wprod[30:0];
      end
      if (v1_ff) begin
         prod_ff <= pix * $signed({1'b0, wgt_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[wr_addr] <= pixel_value;
      end else if (mem_re) begin
         rdata_ff <= plane_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_write_during_fetch: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("plane write collides with a neighbour read");

   a_drained_at_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (!v1_ff && !v2_ff))
      else $error("rounding started before the accumulate pipeline emptied");

   a_result_from_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ROUND))
      else $error("result appeared outside the rounding step");

   a_fetch_four_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && step_ff == 2'd0) |-> ($past(state_ff) == ST_FETCH
      && $past(step_ff) == 2'd3))
      else $error("neighbour fetch ended early");

endmodule

// ----- sim/bilinear_grid_sampler_checker.sv -----
module bilinear_grid_sampler_checker
   import bgs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic                    req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      failures,
   output int                      outstanding
);

   localparam longint ONE_Q15  = longint'(1) <<< FRAC_BITS;
   localparam longint HALF_Q30 = longint'(1) <<< 29;

   typedef struct packed {
      logic [GRID_W-1:0]  grid_y;
      logic [GRID_W-1:0]  grid_x;
      logic [PIX_W-1:0]   pixel_value;
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
   } request_fields_type;

   logic signed [PIX_W-1:0] image_copy [0:MAX_HEIGHT_DEF*MAX_WIDTH_DEF-1];
   logic                    border_mode;
   logic                    align_mode;
   logic [SIZE_W-1:0]       rows_cfg;
   logic [SIZE_W-1:0]       cols_cfg;
   logic [RSP_DATA_W-1:0]   expected_samples [$];

   function automatic longint effective_size(logic [SIZE_W-1:0] value, int limit);
      if (value == 0)
         return 1;
      if (value > limit)
         return limit;
      return value;
   endfunction

   function automatic longint pixel_position(logic [GRID_W-1:0] raw, longint size);
      longint g;
      g = longint'($signed(raw));
      if (align_mode)
         return (g + 16384) * (size - 1);
      return (g + 16384) * size - 16384;
   endfunction

   function automatic longint plane_pixel(longint r, longint c, longint rows, longint cols);
      if (border_mode) begin
         if (r < 0) r = 0;
         if (r > rows - 1) r = rows - 1;
         if (c < 0) c = 0;
         if (c > cols - 1) c = cols - 1;
      end else if (r < 0 || r >= rows || c < 0 || c >= cols) begin
         return 0;
      end
      return longint'(image_copy[r * MAX_WIDTH_DEF + c]);
   endfunction

   function automatic logic [RSP_DATA_W-1:0] bilinear_value(logic [GRID_W-1:0] gx,
                                                            logic [GRID_W-1:0] gy);
      longint rows, cols, xs, ys, x0, y0, fx, fy, acc, rounded;
      rows = effective_size(rows_cfg, MAX_HEIGHT_DEF);
      cols = effective_size(cols_cfg, MAX_WIDTH_DEF);
      xs = pixel_position(gx, cols);
      ys = pixel_position(gy, rows);
      x0 = xs >>> FRAC_BITS;
      y0 = ys >>> FRAC_BITS;
      fx = xs - (x0 <<< FRAC_BITS);
      fy = ys - (y0 <<< FRAC_BITS);
      acc = (ONE_Q15 - fx) * (ONE_Q15 - fy) * plane_pixel(y0, x0, rows, cols)
          + fx * (ONE_Q15 - fy) * plane_pixel(y0, x0 + 1, rows, cols)
          + (ONE_Q15 - fx) * fy * plane_pixel(y0 + 1, x0, rows, cols)
          + fx * fy * plane_pixel(y0 + 1, x0 + 1, rows, cols);
      rounded = (acc + HALF_Q30) >>> 30;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      return rounded[RSP_DATA_W-1:0];
   endfunction

   always @(posedge clock) begin
      request_fields_type     fields;
      logic [RSP_DATA_W-1:0]  wanted;
      if (reset) begin
         border_mode = 1'b0;
         align_mode = 1'b0;
         rows_cfg = SIZE_RESET;
         cols_cfg = SIZE_RESET;
         expected_samples.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BORDER_PADDING: border_mode = csr_wdata[0];
               CSR_ALIGN_CORNERS:  align_mode = csr_wdata[0];
               CSR_PLANE_HEIGHT:   rows_cfg = csr_wdata[SIZE_W-1:0];
               CSR_PLANE_WIDTH:    cols_cfg = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_value unexpected: expected none, actual %0d",
                      $signed(rsp_tdata));
               failures++;
            end else begin
               wanted = expected_samples.pop_front();
               if (rsp_tdata !== wanted) begin
                  $error("sample_value mismatch: expected %0d, actual %0d",
                         $signed(wanted), $signed(rsp_tdata));
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fields = req_tdata[$bits(request_fields_type)-1:0];
            if (req_tuser == MODE_LOAD)
               image_copy[fields.pixel_row * MAX_WIDTH_DEF + fields.pixel_col] =
                  fields.pixel_value;
            else
               expected_samples.push_back(bilinear_value(fields.grid_x, fields.grid_y));
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

// ----- sim/bilinear_grid_sampler_test.sv -----
module bilinear_grid_sampler_test;
   import bgs_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int BATCHES       = 13;
   localparam int BATCH_ITEMS   = 70;
   localparam int FILL_COLS     = 16;

   typedef struct {
      logic              border;
      logic              align;
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
   } plane_setup_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = MODE_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    outstanding;
   int                    req_idle_pct = 22;
   int                    rsp_idle_pct = 79;
   int                    hold_token = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    cycle_count = 0;

   bilinear_grid_sampler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bilinear_grid_sampler_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic push_request(input logic mode, input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col, input logic [PIX_W-1:0] value,
                               input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(REQ_DATA_W - 2 * GRID_W - PIX_W - 2 * COORD_W){1'b0}},
                    gy, gx, value, col, row};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic push_load(input int row, input int col, input logic [PIX_W-1:0] value);
      push_request(MODE_LOAD, COORD_W'(row), COORD_W'(col), value,
                   GRID_W'($urandom), GRID_W'($urandom));
   endtask

   task automatic push_sample(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy);
      push_request(MODE_SAMPLE, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom),
                   gx, gy);
   endtask

   function automatic logic [GRID_W-1:0] random_grid();
      case ($urandom_range(3))
         0: return GRID_W'($urandom);
         1: return GRID_W'($urandom_range(34000) - 17000);
         2: case ($urandom_range(4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'hC000;
               3: return 16'h4000;
               default: return 16'h0000;
            endcase
         default: return GRID_W'($urandom_range(4400) - 2200);
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      plane_setup_type setups [BATCHES];
      setups[0] = '{1'b0, 1'b0, 7'd64, 7'd16};
      setups[1] = '{1'b1, 1'b1, 7'd1, 7'd1};
      setups[2] = '{1'b0, 1'b1, 7'd2, 7'd3};
      setups[3] = '{1'b1, 1'b0, 7'd0, 7'd16};
      setups[4] = '{1'b0, 1'b1, 7'd65, 7'd1};
      setups[5] = '{1'b1, 1'b1, 7'd127, 7'd16};
      setups[6] = '{1'b0, 1'b0, 7'd1, 7'd2};
      setups[7] = '{1'b1, 1'b0, 7'd64, 7'd0};
      for (int b = 8; b < BATCHES; b++)
         setups[b] = '{1'($urandom_range(1)), 1'($urandom_range(1)),
                       SIZE_W'($urandom_range(127)), SIZE_W'($urandom_range(FILL_COLS))};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every pixel that a sample can reach is written first, and plane widths stay
      // within the filled columns.
      for (int r = 0; r < MAX_HEIGHT_DEF; r++)
         for (int c = 0; c < FILL_COLS; c++)
            push_load(r, c, PIX_W'($urandom));
      drain_block();
      write_register(CSR_PLANE_WIDTH, CSR_DATA_W'(FILL_COLS));

      push_load(0, 0, 16'h8000);
      push_load(0, 1, 16'h7FFF);
      push_load(1, 0, 16'h7FFF);
      push_load(1, 1, 16'h8000);
      push_load(63, FILL_COLS - 1, 16'h7FFF);
      push_load(62, FILL_COLS - 1, 16'h0001);
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h7FFF, 16'h7FFF);
      push_sample(16'h7FFF, 16'h8000);
      push_sample(16'h0000, 16'h0000);
      push_sample(16'hC000, 16'hC000);
      push_sample(16'h4000, 16'h4000);
      push_sample(16'hC200, 16'hC000);
      push_sample(16'hC200, 16'hC200);
      push_sample(16'h3FFF, 16'h3E00);
      push_sample(16'hFFFF, 16'h0001);
      drain_block();

      for (int b = 0; b < BATCHES; b++) begin
         if (b == 5) begin
            req_idle_pct = 79;
            rsp_idle_pct = 22;
         end else if (b == 9) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_register(CSR_BORDER_PADDING, {6'($urandom), setups[b].border});
         write_register(CSR_ALIGN_CORNERS, {6'($urandom), setups[b].align});
         write_register(CSR_PLANE_HEIGHT, setups[b].rows);
         write_register(CSR_PLANE_WIDTH, setups[b].cols);
         if (b == 9)
            hold_token++;
         for (int i = 0; i < BATCH_ITEMS; i++) begin
            if ($urandom_range(99) < 25)
               push_load($urandom_range(63), $urandom_range(63), PIX_W'($urandom));
            else
               push_sample(random_grid(), random_grid());
         end
         drain_block();
      end

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
